/* hdl/lkc_pkg.sv */
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared sizes for the LRU key cache.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int ENTRIES  = 8;
  localparam int KEY_BITS = 8;
  localparam int CAP_W    = 4;
  localparam int OCC_W    = 4;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int AGE_W    = IDX_W;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int CMP_W    = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

endpackage

/* hdl/lkc_in_if.sv */
// ----------------------------------------------------------------------------
// lkc_in_if
// Access channel: one key per word.
// ----------------------------------------------------------------------------
interface lkc_in_if;

  logic                          valid;
  logic                          ready;
  logic [lkc_pkg::KEY_BITS-1:0]  access_key;

  modport source (output valid, output access_key, input ready);
  modport sink   (input valid, input access_key, output ready);

endinterface

/* hdl/lkc_out_if.sv */
// ----------------------------------------------------------------------------
// lkc_out_if
// Result channel: hit/evict status and occupancy per word.
// ----------------------------------------------------------------------------
interface lkc_out_if;

  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          evicted;
  logic [lkc_pkg::KEY_BITS-1:0]  evicted_key;
  logic [lkc_pkg::OCC_W-1:0]     occupancy;

  modport source (output valid, output hit, output evicted, output evicted_key,
                  output occupancy, input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_key,
                  input occupancy, output ready);

endinterface

/* hdl/lru_key_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_cache
// Fully associative key cache with least-recently-used replacement.
//
//   channel   dir   handshake         payload
//   in_ch     in    valid/ready       access_key
//   out_ch    out   valid/ready       hit, evicted, evicted_key, occupancy
//   cfg       in    cfg_wr_en         cfg_wr_data (capacity)
//
// One access per clock while out_ch is not stalled, through the key register,
// then the result register. Tag compare and age update are combinational.
// Reset clears valid bits, ages, fill count and sets capacity to 8.
// A stalled result holds the pipe; one more word is taken into the key
// register while the result waits.
// ----------------------------------------------------------------------------
module lru_key_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  lkc_in_if.sink                     in_ch,
  lkc_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  logic [lkc_pkg::CAP_W-1:0]  cfg_wr_data
);

  logic [lkc_pkg::CAP_W-1:0]     cap_r;
  logic                          in_v_r;
  logic [lkc_pkg::KEY_BITS-1:0]  key_r;
  logic [lkc_pkg::KEY_BITS-1:0]  entry_key_r   [lkc_pkg::ENTRIES];
  logic [lkc_pkg::AGE_W-1:0]     entry_age_r   [lkc_pkg::ENTRIES];
  logic [lkc_pkg::AGE_W-1:0]     entry_age_nxt [lkc_pkg::ENTRIES];
  logic [lkc_pkg::ENTRIES-1:0]   entry_valid_r;
  logic [lkc_pkg::ENTRIES-1:0]   entry_valid_nxt;
  logic [lkc_pkg::CNT_W-1:0]     filled_r;
  logic [lkc_pkg::CNT_W-1:0]     filled_nxt;

  logic                          out_v_r;
  logic                          hit_r;
  logic                          evicted_r;
  logic [lkc_pkg::KEY_BITS-1:0]  evicted_key_r;
  logic [lkc_pkg::OCC_W-1:0]     occupancy_r;

  logic                          adv;
  logic                          proc;
  logic [lkc_pkg::ENTRIES-1:0]   hit_vec;
  logic                          hit_any;
  logic [lkc_pkg::IDX_W-1:0]     hit_idx;
  logic [lkc_pkg::IDX_W-1:0]     victim_idx;
  logic [lkc_pkg::IDX_W-1:0]     free_idx;
  logic [lkc_pkg::IDX_W-1:0]     slot;
  logic [lkc_pkg::CNT_W-1:0]     limit;
  logic [lkc_pkg::CMP_W-1:0]     eff_cap;
  logic                          full;
  logic                          ins;
  logic [lkc_pkg::AGE_W-1:0]     oldest;
  logic [lkc_pkg::KEY_BITS-1:0]  victim_key;

  assign adv          = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !in_v_r || adv;
  assign proc         = in_v_r && adv;

  assign out_ch.valid       = out_v_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.evicted     = evicted_r;
  assign out_ch.evicted_key = evicted_key_r;
  assign out_ch.occupancy   = occupancy_r;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lkc_pkg::CMP_W'(1);
    end else if (lkc_pkg::CMP_W'(cap_r) > lkc_pkg::CMP_W'(lkc_pkg::ENTRIES)) begin
      eff_cap = lkc_pkg::CMP_W'(lkc_pkg::ENTRIES);
    end else begin
      eff_cap = lkc_pkg::CMP_W'(cap_r);
    end
  end

  assign full   = lkc_pkg::CMP_W'(filled_r) >= eff_cap;
  assign oldest = lkc_pkg::AGE_W'(filled_r - lkc_pkg::CNT_W'(1));

  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = lkc_pkg::ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = entry_valid_r[i] && (entry_key_r[i] == key_r);
      if (hit_vec[i]) begin
        hit_idx = lkc_pkg::IDX_W'(i);
      end
      if (entry_valid_r[i] && (entry_age_r[i] == oldest)) begin
        victim_idx = lkc_pkg::IDX_W'(i);
      end
      if (!entry_valid_r[i]) begin
        free_idx = lkc_pkg::IDX_W'(i);
      end
    end
  end

  assign hit_any    = |hit_vec;
  assign ins        = !hit_any && !full;
  assign victim_key = entry_key_r[victim_idx];

  always_comb begin
    if (hit_any) begin
      slot  = hit_idx;
      limit = lkc_pkg::CNT_W'(entry_age_r[hit_idx]);
    end else if (full) begin
      slot  = victim_idx;
      limit = lkc_pkg::CNT_W'(oldest);
    end else begin
      slot  = free_idx;
      limit = lkc_pkg::CNT_W'(lkc_pkg::ENTRIES);
    end
  end

  always_comb begin
    entry_valid_nxt = entry_valid_r;
    filled_nxt      = filled_r;
    if (ins) begin
      entry_valid_nxt[slot] = 1'b1;
      filled_nxt            = filled_r + lkc_pkg::CNT_W'(1);
    end
    for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
      entry_age_nxt[i] = entry_age_r[i];
      if (lkc_pkg::IDX_W'(i) == slot) begin
        entry_age_nxt[i] = '0;
      end else if (entry_valid_r[i] && (lkc_pkg::CNT_W'(entry_age_r[i]) < limit)) begin
        entry_age_nxt[i] = entry_age_r[i] + lkc_pkg::AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r         <= lkc_pkg::CAP_RESET;
      in_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      entry_valid_r <= '0;
      filled_r      <= '0;
      for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
        entry_age_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= in_v_r;
      end
      if (proc) begin
        entry_valid_r <= entry_valid_nxt;
        filled_r      <= filled_nxt;
        entry_age_r   <= entry_age_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      key_r <= in_ch.access_key;
    end
    if (proc) begin
      if (!hit_any) begin
        entry_key_r[slot] <= key_r;
      end
      hit_r         <= hit_any;
      evicted_r     <= !hit_any && full;
      evicted_key_r <= (!hit_any && full) ? victim_key : '0;
      occupancy_r   <= lkc_pkg::OCC_W'(filled_nxt);
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lkc_pkg::CNT_W'(filled_r) <= lkc_pkg::CNT_W'(lkc_pkg::ENTRIES))
    else $error("fill count above entry count");

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(entry_valid_r) == int'(filled_r))
    else $error("fill count differs from valid bits");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |-> $onehot0(hit_vec))
    else $error("key held in more than one entry");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(hit_r && evicted_r))
    else $error("hit and eviction on one word");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ins) |=> filled_r == $past(filled_r) + lkc_pkg::CNT_W'(1))
    else $error("insert did not grow fill count");
`endif

endmodule

/* dv/lru_key_cache_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_cache_test
// Self-checking bench for the LRU key cache. A short table of directed
// accesses and capacity writes runs first, then phases of random accesses
// drawn mostly from a small key pool so hits, misses and evictions all occur.
// Each result is checked against a cycle-free LRU predictor or its row's want.
// ----------------------------------------------------------------------------
module lru_key_cache_test;

  typedef struct packed {
    logic                         hit;
    logic                         evicted;
    logic [lkc_pkg::KEY_BITS-1:0] evicted_key;
    logic [lkc_pkg::OCC_W-1:0]    occupancy;
  } lookup_t;

  typedef enum logic {ROW_CAP, ROW_ACCESS} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [lkc_pkg::CAP_W-1:0]    cap;
    logic [lkc_pkg::KEY_BITS-1:0] key;
    logic                         typed;
    lookup_t                      want;
  } access_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [lkc_pkg::KEY_BITS-1:0] in_key = '0;
  logic rsp_ready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [lkc_pkg::CAP_W-1:0] cfg_wr_data = '0;

  // typed expectation travels with the word it belongs to
  logic row_typed = 1'b0;
  lookup_t row_expect = '0;

  bit calm = 1'b0;
  int stall_left = 0;
  int err_count = 0;

  lookup_t pending_lookups[$];

  // predictor state
  logic [lkc_pkg::KEY_BITS-1:0] tag_q [lkc_pkg::ENTRIES];
  bit                           line_vld [lkc_pkg::ENTRIES];
  int unsigned                  line_age [lkc_pkg::ENTRIES];
  int unsigned                  fill_cnt = 0;
  logic [lkc_pkg::CAP_W-1:0]    cap_shadow = lkc_pkg::CAP_RESET;

  lkc_in_if  in_ch ();
  lkc_out_if out_ch ();

  assign in_ch.valid      = in_valid;
  assign in_ch.access_key = in_key;
  assign out_ch.ready     = rsp_ready;

  lru_key_cache dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void age_younger(int slot, int unsigned limit);
    for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
      if (line_vld[i] && i != slot && line_age[i] < limit) line_age[i]++;
    end
    line_age[slot] = 0;
  endfunction

  function automatic lookup_t lru_lookup(logic [lkc_pkg::KEY_BITS-1:0] key);
    lookup_t     r;
    int          found;
    int          victim;
    int          slot;
    int unsigned oldest;
    int unsigned cap_eff;
    r       = '0;
    found   = -1;
    victim  = -1;
    slot    = -1;
    oldest  = 0;
    cap_eff = (cap_shadow == 0) ? 1 :
              ((cap_shadow > lkc_pkg::ENTRIES) ? lkc_pkg::ENTRIES : cap_shadow);
    for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
      if (found < 0 && line_vld[i] && tag_q[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      age_younger(found, line_age[found]);
    end else if (fill_cnt >= cap_eff) begin
      for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
        if (line_vld[i] && (victim < 0 || line_age[i] > oldest)) begin
          victim = i;
          oldest = line_age[i];
        end
      end
      if (victim >= 0) begin
        r.evicted     = 1'b1;
        r.evicted_key = tag_q[victim];
        tag_q[victim] = key;
        age_younger(victim, oldest);
      end
    end else begin
      for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
        if (slot < 0 && !line_vld[i]) slot = i;
      end
      if (slot >= 0) begin
        line_vld[slot] = 1'b1;
        tag_q[slot]    = key;
        age_younger(slot, lkc_pkg::ENTRIES);
        fill_cnt++;
      end
    end
    r.occupancy = lkc_pkg::OCC_W'(fill_cnt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left <= gap_len();
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lookup_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = lru_lookup(in_ch.access_key);
        if (row_typed) want = row_expect;
        pending_lookups.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_lookups.size() == 0) begin
          $error("result word with no access waiting");
          err_count++;
        end else begin
          want = pending_lookups.pop_front();
          check_field("hit", 8'(want.hit), 8'(out_ch.hit));
          check_field("evicted", 8'(want.evicted), 8'(out_ch.evicted));
          check_field("evicted_key", 8'(want.evicted_key), 8'(out_ch.evicted_key));
          check_field("occupancy", 8'(want.occupancy), 8'(out_ch.occupancy));
        end
      end
    end
  end

  function automatic access_row_t cap_row(logic [lkc_pkg::CAP_W-1:0] v);
    access_row_t r;
    r      = '0;
    r.kind = ROW_CAP;
    r.cap  = v;
    return r;
  endfunction

  function automatic access_row_t key_row(logic [lkc_pkg::KEY_BITS-1:0] k);
    access_row_t r;
    r      = '0;
    r.kind = ROW_ACCESS;
    r.key  = k;
    return r;
  endfunction

  function automatic access_row_t known_row(logic [lkc_pkg::KEY_BITS-1:0] k, logic h,
                                            logic e, logic [lkc_pkg::KEY_BITS-1:0] ek,
                                            logic [lkc_pkg::OCC_W-1:0] occ);
    access_row_t r;
    r                  = key_row(k);
    r.typed            = 1'b1;
    r.want.hit         = h;
    r.want.evicted     = e;
    r.want.evicted_key = ek;
    r.want.occupancy   = occ;
    return r;
  endfunction

  task automatic send_access(logic [lkc_pkg::KEY_BITS-1:0] key, logic typed,
                             lookup_t want);
    int gap;
    in_key     <= key;
    row_typed  <= typed;
    row_expect <= want;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
  endtask

  task automatic write_capacity(logic [lkc_pkg::CAP_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_shadow  = v;
  endtask

  initial begin
    access_row_t                  dir_rows[$];
    logic [lkc_pkg::KEY_BITS-1:0] key_pool [10];
    logic [lkc_pkg::KEY_BITS-1:0] k;
    logic [lkc_pkg::CAP_W-1:0]    cap;
    logic [lkc_pkg::CAP_W-1:0]    cap_plan [8];

    cap_plan = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd4, 4'd2, 4'd7, 4'd9};

    // zero capacity acts as one
    dir_rows.push_back(cap_row(4'd0));
    dir_rows.push_back(known_row(8'h00, 1'b0, 1'b0, 8'h00, 4'd1));
    dir_rows.push_back(known_row(8'h00, 1'b1, 1'b0, 8'h00, 4'd1));
    dir_rows.push_back(known_row(8'hFF, 1'b0, 1'b1, 8'h00, 4'd1));
    dir_rows.push_back(known_row(8'h01, 1'b0, 1'b1, 8'hFF, 4'd1));
    // oversize capacity saturates at the entry count
    dir_rows.push_back(cap_row(4'd15));
    for (int i = 2; i <= 8; i++)
      dir_rows.push_back(known_row(8'(i), 1'b0, 1'b0, 8'h00, 4'(i)));
    dir_rows.push_back(known_row(8'hAA, 1'b0, 1'b1, 8'h01, 4'd8));
    dir_rows.push_back(known_row(8'h05, 1'b1, 1'b0, 8'h00, 4'd8));
    dir_rows.push_back(key_row(8'h80));
    dir_rows.push_back(key_row(8'h7F));
    // capacity below occupancy: occupancy holds
    dir_rows.push_back(cap_row(4'd3));
    dir_rows.push_back(key_row(8'h10));
    dir_rows.push_back(key_row(8'h05));
    dir_rows.push_back(key_row(8'h11));
    dir_rows.push_back(cap_row(lkc_pkg::CAP_RESET));
    dir_rows.push_back(key_row(8'hFE));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        wait_drained();
        write_capacity(dir_rows[i].cap);
      end else begin
        send_access(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      cap = (ph == 7) ? lkc_pkg::CAP_W'($urandom_range(0, 15)) : cap_plan[ph];
      write_capacity(cap);
      calm = (ph % 3 == 1);
      for (int j = 0; j < 10; j++) key_pool[j] = lkc_pkg::KEY_BITS'($urandom);
      for (int n = 0; n < 205; n++) begin
        if ($urandom_range(0, 99) < 75) k = key_pool[$urandom_range(0, 9)];
        else k = lkc_pkg::KEY_BITS'($urandom);
        send_access(k, 1'b0, '0);
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_lookups.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
